// ===== hdl/dnes_pkg.sv =====
package dnes_pkg;

	localparam int VALUE_W = 31;
	localparam int MAX_COUNT_DEF = 64;
	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	// acc * 10 + 9 fits here for any acc below 2^31
	localparam int PROD_W = VALUE_W + 4;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_line;
	} text_t;

	typedef struct packed {
		logic [VALUE_W-1:0] number_value;
		logic               last_number;
	} num_t;

	// what one cell shows its neighbors
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               valid;
		logic               gt;
	} link_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic               insert;
		logic               shift;
		logic [VALUE_W-1:0] value;
	} cmd_t;

endpackage

// ===== hdl/decimal_number_extract_sort.sv =====
// Decimal number extraction with ascending sort.
// text channel: one character per transfer, end_of_line flags the last
// character of a line. Runs of ASCII digits become unsigned numbers that
// saturate at 2^31-1; up to MAX_COUNT numbers per line are kept, later
// ones are dropped.
// Within a line one character is taken every cycle: a closed number goes
// through one register stage and is then inserted into a chain of
// MAX_COUNT sorting cells.
// After the end-of-line transfer, text_stall stays high while the line
// is flushed: the end-of-line flag is registered and starts the drain,
// and each popped number is registered onto num, one number per cycle
// while num_stall is low, with last_number on the largest. A line with
// no number gives no num transfer.
// A high num_stall holds a shown number and freezes the chain.
// Reset empties the chain, the accumulator and the output valid flag.
module decimal_number_extract_sort #(
	parameter int MAX_COUNT = dnes_pkg::MAX_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            text_valid,
	output logic            text_stall,
	input  dnes_pkg::text_t text,
	output logic            num_valid,
	input  logic            num_stall,
	output dnes_pkg::num_t  num
);
	import dnes_pkg::*;

	logic [VALUE_W-1:0] acc_q;
	logic               inside_q;
	logic               ins_s1;
	logic               eol_s1;
	logic [VALUE_W-1:0] value_s1;
	logic               drain_q;
	logic               num_valid_q;
	num_t               num_q;

	logic               accept;
	logic               is_digit;
	logic [PROD_W-1:0]  prod;
	logic [VALUE_W-1:0] acc_next;
	logic               close;
	logic               pop;
	cmd_t               cmd;
	link_t              head;
	logic               head_last;
	logic               full;

	assign text_stall = eol_s1 || drain_q;
	assign accept     = text_valid && !text_stall;
	assign is_digit   = text.text_byte inside {[CHAR_ZERO:CHAR_NINE]};

	// acc * 10 as two shifts
	assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ {{(PROD_W-8){1'b0}}, text.text_byte - CHAR_ZERO};
	assign acc_next = (prod > {4'b0, VALUE_MAX}) ? VALUE_MAX : prod[VALUE_W-1:0];

	assign close = (!is_digit && inside_q) || (text.end_of_line && (is_digit || inside_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			inside_q <= 1'b0;
		end else if (accept) begin
			if (text.end_of_line || !is_digit) begin
				acc_q    <= '0;
				inside_q <= 1'b0;
			end else begin
				acc_q    <= acc_next;
				inside_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_s1 <= 1'b0;
			eol_s1 <= 1'b0;
		end else begin
			ins_s1 <= accept && close;
			eol_s1 <= accept && text.end_of_line;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= is_digit ? acc_next : acc_q;
		end
	end

	assign pop = drain_q && head.valid && (!num_valid_q || !num_stall);

	assign cmd.insert = ins_s1 && !full;
	assign cmd.shift  = pop;
	assign cmd.value  = value_s1;

	dnes_chain #(
		.MAX_COUNT (MAX_COUNT)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.head      (head),
		.head_last (head_last),
		.full      (full)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
		end else if (eol_s1) begin
			drain_q <= 1'b1;
		end else if (drain_q && !head.valid) begin
			drain_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_valid_q <= 1'b0;
		end else if (pop) begin
			num_valid_q <= 1'b1;
		end else if (!num_stall) begin
			num_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			num_q.number_value <= head.value;
			num_q.last_number  <= head_last;
		end
	end

	assign num_valid = num_valid_q;
	assign num       = num_q;

endmodule

// ===== hdl/dnes_cell.sv =====
module dnes_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  dnes_pkg::cmd_t cmd,
	input  dnes_pkg::link_t left,
	input  dnes_pkg::link_t right,
	output dnes_pkg::link_t link
);
	import dnes_pkg::*;

	logic [VALUE_W-1:0] value_q;
	logic               valid_q;
	logic               gt;
	logic               take;

	assign gt = valid_q && (value_q > cmd.value);
	// a larger value moves right, and the first empty cell opens up too
	assign take = cmd.insert && (gt || (!valid_q && left.valid));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (cmd.shift) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			value_q <= left.gt ? left.value : cmd.value;
		end else if (cmd.shift) begin
			value_q <= right.value;
		end
	end

	assign link.value = value_q;
	assign link.valid = valid_q;
	assign link.gt    = gt;

endmodule

// ===== hdl/dnes_chain.sv =====
module dnes_chain #(
	parameter int MAX_COUNT = dnes_pkg::MAX_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dnes_pkg::cmd_t  cmd,
	output dnes_pkg::link_t head,
	output logic            head_last,
	output logic            full
);
	import dnes_pkg::*;

	link_t links [0:MAX_COUNT];
	link_t lefts [0:MAX_COUNT-1];

	assign links[MAX_COUNT] = '{value: '0, valid: 1'b0, gt: 1'b0};

	genvar i;
	generate
		for (i = 0; i < MAX_COUNT; i++) begin : g_cell
			if (i == 0) begin : g_first
				assign lefts[i] = '{value: '0, valid: 1'b1, gt: 1'b0};
			end else begin : g_rest
				assign lefts[i] = links[i-1];
			end
			dnes_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd),
				.left   (lefts[i]),
				.right  (links[i+1]),
				.link   (links[i])
			);
		end
	endgenerate

	assign head      = links[0];
	assign head_last = !links[1].valid;
	assign full      = links[MAX_COUNT-1].valid;

endmodule

// ===== hdl/dnes_checker.sv =====
module dnes_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            text_valid,
	input logic            text_stall,
	input dnes_pkg::text_t text,
	input logic            num_valid,
	input logic            num_stall,
	input dnes_pkg::num_t  num
);
	import dnes_pkg::*;

	// held number stays put while stalled
	a_num_hold: assert property (@(posedge clk) disable iff (!arst_n)
		num_valid && num_stall |=> num_valid && $stable(num))
		else $error("num changed while stalled");

	// a line end blocks further characters during the flush
	a_eol_busy: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_stall && text.end_of_line |=> text_stall)
		else $error("text taken right after end of line");

	// a sorted run continues without gaps until its last number
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		num_valid && !num_stall && !num.last_number |=> num_valid)
		else $error("gap inside sorted run");

	// numbers only come out while the line is being flushed
	a_num_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(num_valid) |-> text_stall)
		else $error("number emitted outside flush");

endmodule

bind decimal_number_extract_sort dnes_checker u_dnes_checker (.*);

// ===== dv/decimal_number_extract_sort_check.sv =====
`timescale 1ns / 1ps
module decimal_number_extract_sort_check #(
	parameter int MAX_COUNT = dnes_pkg::MAX_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            text_valid,
	input  logic            text_stall,
	input  dnes_pkg::text_t text,
	input  logic            num_valid,
	input  logic            num_stall,
	input  dnes_pkg::num_t  num,
	output int              outstanding,
	output int              mismatches
);
	import dnes_pkg::*;

	// numbers of the line in progress, kept ascending
	logic [VALUE_W-1:0] line_nums[$];
	logic [VALUE_W-1:0] acc = '0;
	logic               in_digits = 1'b0;
	num_t               sorted_due_q[$];
	int                 fails = 0;
	int                 due_count = 0;

	assign outstanding = due_count;
	assign mismatches  = fails;

	function automatic void close_number();
		int pos;
		if (in_digits) begin
			if (line_nums.size() < MAX_COUNT) begin
				pos = line_nums.size();
				while (pos > 0 && line_nums[pos - 1] > acc)
					pos--;
				line_nums.insert(pos, acc);
			end
			acc = '0;
			in_digits = 1'b0;
		end
	endfunction

	function automatic void take_char(text_t t);
		longint unsigned grown;
		if (t.text_byte >= CHAR_ZERO && t.text_byte <= CHAR_NINE) begin
			grown = 64'(acc) * 64'd10 + 64'(t.text_byte - CHAR_ZERO);
			// saturate instead of wrapping
			if (grown > 64'(VALUE_MAX))
				acc = VALUE_MAX;
			else
				acc = grown[VALUE_W-1:0];
			in_digits = 1'b1;
		end else begin
			close_number();
		end
		if (t.end_of_line) begin
			close_number();
			foreach (line_nums[i])
				sorted_due_q.push_back('{number_value: line_nums[i],
					last_number: (i == line_nums.size() - 1)});
			line_nums.delete();
			acc = '0;
			in_digits = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		num_t want;
		if (!arst_n) begin
			line_nums.delete();
			sorted_due_q.delete();
			acc = '0;
			in_digits = 1'b0;
			due_count <= 0;
		end else begin
			if (num_valid && !num_stall) begin
				if (sorted_due_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected num transfer: value %0d last %0b",
							num.number_value, num.last_number);
				end else begin
					want = sorted_due_q.pop_front();
					if (num.number_value !== want.number_value ||
							num.last_number !== want.last_number) begin
						fails++;
						if (fails <= 10)
							$display("num mismatch: expected value %0d last %0b, got value %0d last %0b",
								want.number_value, want.last_number,
								num.number_value, num.last_number);
					end
				end
			end
			if (text_valid && !text_stall)
				take_char(text);
			due_count <= sorted_due_q.size();
		end
	end

endmodule

// ===== dv/decimal_number_extract_sort_test.sv =====
`timescale 1ns / 1ps
module decimal_number_extract_sort_test;
	import dnes_pkg::*;

	localparam int RANDOM_CHARS = 230;
	localparam int CYCLE_LIMIT = 400000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       text_valid = 1'b0;
	logic       text_stall;
	text_t      text = '0;
	logic       num_valid;
	logic       num_stall = 1'b0;
	num_t       num;
	int         outstanding;
	int         mismatches;
	bit         calm = 1'b0;
	int         stall_left = 0;
	int         cycles = 0;
	int         random_sent = 0;
	logic [7:0] line_q[$];

	always #2 clk = ~clk;

	decimal_number_extract_sort u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text),
		.num_valid  (num_valid),
		.num_stall  (num_stall),
		.num        (num)
	);

	decimal_number_extract_sort_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.text        (text),
		.num_valid   (num_valid),
		.num_stall   (num_stall),
		.num         (num),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("decimal_number_extract_sort test failed");
			$finish;
		end
	end

	// mostly short pauses, a few long ones
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		int n;
		if (calm) begin
			stall_left <= 0;
			num_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			num_stall <= 1'b1;
		end else begin
			n = pause_len();
			num_stall <= (n > 0);
			stall_left <= (n > 0) ? n - 1 : 0;
		end
	end

	task automatic send_char(input logic [7:0] c, input logic eol);
		int gap;
		text_valid <= 1'b1;
		text <= '{text_byte: c, end_of_line: eol};
		do @(posedge clk); while (text_stall);
		gap = calm ? 0 : pause_len();
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_line();
		foreach (line_q[i])
			send_char(line_q[i], i == line_q.size() - 1);
		line_q.delete();
	endtask

	task automatic push_text(input string s);
		foreach (s[i])
			line_q.push_back(s[i]);
	endtask

	task automatic add_number(input int digits);
		repeat (digits)
			line_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic add_sep();
		logic [7:0] b;
		repeat ($urandom_range(1, 2)) begin
			do b = 8'($urandom_range(0, 255));
			while (b >= CHAR_ZERO && b <= CHAR_NINE);
			line_q.push_back(b);
		end
	endtask

	// long runs push the accumulator into saturation
	function automatic int digit_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 9);
		return $urandom_range(10, 12);
	endfunction

	initial begin : stimulus
		int n;
		int line_idx;
		bit paused;
		paused = 1'b0;
		line_idx = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_text("0");
		send_line();
		push_text("x");
		send_line();
		push_text("5:5/0");
		send_line();
		push_text("2147483648");
		send_line();
		line_q = '{8'h00, 8'h33, 8'hff};
		send_line();

		while (random_sent < RANDOM_CHARS) begin
			calm <= ($urandom_range(0, 5) == 0);
			if (!paused && random_sent >= RANDOM_CHARS / 2) begin
				paused = 1'b1;
				text_valid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
			end
			if (line_idx == 3) begin
				// more numbers than the store holds
				repeat ($urandom_range(65, 68)) begin
					add_number(1);
					line_q.push_back(8'h20);
				end
			end else if ($urandom_range(0, 9) < 8) begin
				n = $urandom_range(0, 6);
				if ($urandom_range(0, 1))
					add_sep();
				for (int k = 0; k < n; k++) begin
					add_number(digit_count());
					if (k < n - 1 || $urandom_range(0, 1))
						add_sep();
				end
				if (line_q.size() == 0)
					add_sep();
			end else begin
				repeat ($urandom_range(1, 8))
					line_q.push_back(8'($urandom_range(0, 255)));
			end
			random_sent += line_q.size();
			line_idx++;
			send_line();
		end

		text_valid <= 1'b0;
		calm <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("decimal_number_extract_sort test passed");
		else
			$display("decimal_number_extract_sort test failed");
		$finish;
	end

endmodule
